>>> src/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

    // Widths fixed by the stream format
    localparam int TOTAL_BITS       = 24;
    localparam int BYTE_BITS        = 8;
    localparam int COUNT_BITS_DEF   = 24;
    localparam int RADIX_BITS       = 4;    // hex digit, radix 16
    localparam logic [TOTAL_BITS-1:0] LIMIT_RESET = 24'd999999;

    // Characters
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_HT      = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SIZE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        PR_BEFORE = 2'd0,
        PR_ZERO   = 2'd1,
        PR_DIGITS = 2'd2,
        PR_ENDED  = 2'd3
    } progress_t;

    typedef struct packed {
        logic                 start_req;
        logic [BYTE_BITS-1:0] data_byte;
    } item_t;

    typedef struct packed {
        kind_t                 kind;
        logic [BYTE_BITS-1:0]  body_byte;
        logic [TOTAL_BITS-1:0] total_bytes;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_LOWER_A) + HEX_TEN;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_UPPER_A) + HEX_TEN;
        end
        return h;
    endfunction

    // space, HT, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

>>> src/chunked_body_decoder.sv
`default_nettype none

// Chunked body decoder: takes an HTTP/1.1 chunked body one byte per transfer
// and delivers the decoded body bytes, then one done or error transfer.
// Each size line may start with blanks and an optional 0x; hex digits are
// taken up to the first non-hex byte (extensions are ignored) and the line
// ends at CR LF. A zero size ends the body (done, with the total); a size
// whose total would reach the size limit, or that overflows COUNT_BITS, is an
// error. The two bytes after each chunk's data are dropped unchecked. After
// done or error all bytes are ignored until a transfer with start_req set,
// which clears state and is itself the first byte of a new body. Rate: one
// byte per clock sustained while m_tready is high; a full output register that
// is not taken stalls the input. A byte's result passes from the input register
// through the combinational decode into the output register. The per-byte state
// update is combinational, which sets this rate. The size limit is written over
// the cfg channel, which is always ready; write it only while the block is idle.
module chunked_body_decoder #(
    parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_req

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] body_byte, [31:8] total_bytes
    output logic [1:0]       m_tuser,   // [1:0] kind

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data   // size limit
);

    cbd_pkg::item_t   in_item;
    cbd_pkg::item_t   item;
    cbd_pkg::result_t res;
    cbd_pkg::result_t out_res;
    logic             advance;
    logic             out_free;
    logic             res_valid;

    assign in_item.start_req = s_tuser[0];
    assign in_item.data_byte = s_tdata;

    // register is always writable
    assign cfg_ready = 1'b1;

    cbd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    cbd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_limit    (cfg_data),
        .item_valid   (advance),
        .item         (item),
        .res_valid    (res_valid),
        .res          (res)
    );

    cbd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.total_bytes, out_res.body_byte};
    assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

>>> src/cbd_in_stage.sv
`default_nettype none

module cbd_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cbd_pkg::item_t in_item,
    input  wire logic           out_free,
    output logic                advance,
    output cbd_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    cbd_pkg::item_t item_reg;
    logic           load;

    assign advance  = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;
    assign load     = in_valid && in_ready;
    assign item     = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> src/cbd_decode.sv
`default_nettype none

module cbd_decode #(
    parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [cbd_pkg::TOTAL_BITS-1:0]   cfg_limit,
    input  wire logic                             item_valid,
    input  wire cbd_pkg::item_t                   item,
    output logic                                  res_valid,
    output cbd_pkg::result_t                      res
);

    localparam int TB    = cbd_pkg::TOTAL_BITS;
    localparam int SUM_W = ((COUNT_BITS > TB) ? COUNT_BITS : TB) + 1;
    localparam int RB    = cbd_pkg::RADIX_BITS;

    logic [TB-1:0]          limit_reg;

    cbd_pkg::phase_t        phase_reg, phase_next, phase_cur;
    logic [COUNT_BITS-1:0]  acc_reg, acc_next, acc_cur;
    cbd_pkg::progress_t     prog_reg, prog_next, prog_cur;
    logic                   prev_cr_reg, prev_cr_next, prev_cr_cur;
    logic [COUNT_BITS-1:0]  left_reg, left_next, left_cur;
    logic [1:0]             trail_reg, trail_next, trail_cur;
    logic [TB-1:0]          total_reg, total_next, total_cur;
    logic                   ovf_reg, ovf_next, ovf_cur;

    always_comb begin
        logic [7:0]          c;
        cbd_pkg::hex_t       h;
        logic                take_digit;
        logic [SUM_W-1:0]    size_sum;
        logic [1:0]          trail_dec;

        c          = item.data_byte;
        h          = cbd_pkg::hex_value(c);
        take_digit = 1'b0;
        trail_dec  = 2'd0;

        // start_req clears everything but the size limit before the byte is used
        if (item.start_req) begin
            phase_cur   = cbd_pkg::PH_SIZE;
            acc_cur     = '0;
            prog_cur    = cbd_pkg::PR_BEFORE;
            prev_cr_cur = 1'b0;
            left_cur    = '0;
            trail_cur   = 2'd0;
            total_cur   = '0;
            ovf_cur     = 1'b0;
        end else begin
            phase_cur   = phase_reg;
            acc_cur     = acc_reg;
            prog_cur    = prog_reg;
            prev_cr_cur = prev_cr_reg;
            left_cur    = left_reg;
            trail_cur   = trail_reg;
            total_cur   = total_reg;
            ovf_cur     = ovf_reg;
        end

        size_sum = SUM_W'(total_cur) + SUM_W'(acc_cur);

        phase_next   = phase_cur;
        acc_next     = acc_cur;
        prog_next    = prog_cur;
        prev_cr_next = prev_cr_cur;
        left_next    = left_cur;
        trail_next   = trail_cur;
        total_next   = total_cur;
        ovf_next     = ovf_cur;

        res_valid       = 1'b0;
        res.kind        = cbd_pkg::KIND_DATA;
        res.body_byte   = '0;
        res.total_bytes = total_cur;

        unique case (phase_cur)
            cbd_pkg::PH_SIZE: begin
                if (c == cbd_pkg::CH_LF && prev_cr_cur) begin
                    // end of size line
                    res_valid = 1'b1;
                    priority if (ovf_cur) begin
                        phase_next = cbd_pkg::PH_STOP;
                        res.kind   = cbd_pkg::KIND_ERROR;
                    end else if (acc_cur == '0) begin
                        phase_next = cbd_pkg::PH_STOP;
                        res.kind   = cbd_pkg::KIND_DONE;
                    end else if (size_sum >= SUM_W'(limit_reg)) begin
                        phase_next = cbd_pkg::PH_STOP;
                        res.kind   = cbd_pkg::KIND_ERROR;
                    end else begin
                        res_valid  = 1'b0;
                        left_next  = acc_cur;
                        phase_next = cbd_pkg::PH_DATA;
                    end
                end else begin
                    prev_cr_next = (c == cbd_pkg::CH_CR);
                    unique case (prog_cur)
                        cbd_pkg::PR_BEFORE: begin
                            priority if (c == cbd_pkg::CH_ZERO) begin
                                prog_next = cbd_pkg::PR_ZERO;
                            end else if (h.ok) begin
                                take_digit = 1'b1;
                            end else if (!cbd_pkg::is_blank(c)) begin
                                prog_next = cbd_pkg::PR_ENDED;
                            end
                        end
                        cbd_pkg::PR_ZERO: begin
                            priority if (c == cbd_pkg::CH_LOWER_X ||
                                         c == cbd_pkg::CH_UPPER_X) begin
                                prog_next = cbd_pkg::PR_DIGITS;
                            end else if (h.ok) begin
                                take_digit = 1'b1;
                            end else begin
                                prog_next = cbd_pkg::PR_ENDED;
                            end
                        end
                        cbd_pkg::PR_DIGITS: begin
                            if (h.ok) begin
                                take_digit = 1'b1;
                            end else begin
                                prog_next = cbd_pkg::PR_ENDED;
                            end
                        end
                        default: begin
                            // extensions: ignored until line end
                        end
                    endcase
                    if (take_digit) begin
                        // shift in one nibble; bits shifted out mean overflow
                        ovf_next  = ovf_cur || (|acc_cur[COUNT_BITS-1 -: RB]);
                        acc_next  = {acc_cur[COUNT_BITS-RB-1:0], h.val};
                        prog_next = cbd_pkg::PR_DIGITS;
                    end
                end
            end
            cbd_pkg::PH_DATA: begin
                total_next = total_cur + TB'(1);
                left_next  = (left_cur != '0) ? left_cur - COUNT_BITS'(1) : '0;
                if (left_cur <= COUNT_BITS'(1)) begin
                    phase_next = cbd_pkg::PH_TRAIL;
                    trail_next = 2'd2;
                end
                res_valid       = 1'b1;
                res.kind        = cbd_pkg::KIND_DATA;
                res.body_byte   = c;
                res.total_bytes = total_next;
            end
            cbd_pkg::PH_TRAIL: begin
                trail_dec  = (trail_cur != 2'd0) ? trail_cur - 2'd1 : 2'd0;
                trail_next = trail_dec;
                if (trail_dec == 2'd0) begin
                    phase_next   = cbd_pkg::PH_SIZE;
                    acc_next     = '0;
                    prog_next    = cbd_pkg::PR_BEFORE;
                    prev_cr_next = 1'b0;
                    ovf_next     = 1'b0;
                end
            end
            default: begin
                // stopped after done or error
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= cbd_pkg::LIMIT_RESET;
            phase_reg    <= cbd_pkg::PH_SIZE;
            acc_reg      <= '0;
            prog_reg     <= cbd_pkg::PR_BEFORE;
            prev_cr_reg  <= 1'b0;
            left_reg     <= '0;
            trail_reg    <= 2'd0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_limit;
            end
            if (item_valid) begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                prog_reg    <= prog_next;
                prev_cr_reg <= prev_cr_next;
                left_reg    <= left_next;
                trail_reg   <= trail_next;
                total_reg   <= total_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cbd_out_stage.sv
`default_nettype none

module cbd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             res_valid,
    input  wire cbd_pkg::result_t res,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cbd_pkg::result_t      out_res
);

    logic             valid_reg;
    logic             valid_next;
    cbd_pkg::result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_valid;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
